// ===== rtl/pst_pkg.sv =====
// Shared types and constants for the probabilistic state tracker.
package pst_pkg;

  localparam int PROB_BITS  = 16;
  localparam int FRAC_BITS  = PROB_BITS - 1;
  localparam int NUM_STATES = 16;
  localparam int ST_W       = 4;
  localparam int CNT_W      = 5;
  localparam int TRIG_W     = 8;
  localparam int SLOT_W     = 6;
  localparam int INFLOW_W   = PROB_BITS + 7;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  localparam logic [PROB_BITS-1:0] PROB_ONE = PROB_BITS'(1) << FRAC_BITS;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_TRIGGER = 2'd1;
  localparam logic [1:0] OP_RESET   = 2'd2;
  localparam logic [1:0] OP_QUERY   = 2'd3;

  localparam logic REG_STATE_COUNT   = 1'b0;
  localparam logic REG_INITIAL_STATE = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic [ST_W-1:0]      source;
    logic [ST_W-1:0]      target;
    logic [TRIG_W-1:0]    trig;
    logic [PROB_BITS-1:0] prob;
  } trans_entry_t;

endpackage

// ===== rtl/probabilistic_state_tracker_top.sv =====
// Top level of the probabilistic state tracker: sequencer, state masses and result register.
//
// Each item yields one result. A table write, a reset to a state or a query makes
// one pass over the 16 state masses that finds the most likely state and the
// queried mass, loads the result in S_DONE once the output register is free and
// returns to S_IDLE to accept the next item. A trigger first walks every table
// slot in order with one shared 16x16 multiplier, a multiply state and an
// accumulate state per slot after a state that primes the table read. The input
// is not ready while an item is in work; the finished result sits in an output
// register, so the next item may be accepted while it waits to be taken.
module probabilistic_state_tracker_top #(
  parameter int MAX_TRANSITIONS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // entry_slot, entry_valid, entry_source, entry_target, entry_trigger,
  // entry_prob, event_char, state_index
  input  logic [pst_pkg::IN_DATA_W-1:0]    in_tdata,
  // opcode
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // likely_state, likely_prob, queried_prob
  output logic [pst_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [pst_pkg::CNT_W-1:0]        cfg_wdata
);
  import pst_pkg::*;

  localparam int IDX_W = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int TCNT_W = IDX_W + 1;
  localparam logic [TCNT_W-1:0] T_LAST = TCNT_W'(MAX_TRANSITIONS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRIME = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;

  logic [CNT_W-1:0] state_count_r;
  logic [ST_W-1:0]  initial_state_r;
  logic [CNT_W-1:0] n_used;

  logic [PROB_BITS-1:0] prob_r   [NUM_STATES];
  logic [PROB_BITS-1:0] rest_r   [NUM_STATES];
  logic [INFLOW_W-1:0]  inflow_r [NUM_STATES];

  logic [1:0]           op_r;
  logic [TRIG_W-1:0]    ev_r;
  logic [ST_W-1:0]      qidx_r;
  logic [TCNT_W-1:0]    tidx_r;
  logic [ST_W-1:0]      sidx_r;
  logic [2*PROB_BITS-1:0] prod_r;
  logic [ST_W-1:0]      src_r;
  logic [ST_W-1:0]      tgt_r;
  logic                 ok_r;
  logic [ST_W-1:0]      best_r;
  logic [PROB_BITS-1:0] bestp_r;
  logic [PROB_BITS-1:0] qprob_r;

  logic [ST_W-1:0]      o_likely_r;
  logic [PROB_BITS-1:0] o_lprob_r;
  logic [PROB_BITS-1:0] o_qprob_r;
  logic                 out_valid_r;

  // Input fields
  logic [SLOT_W-1:0]    f_slot;
  logic                 f_valid;
  logic [ST_W-1:0]      f_src;
  logic [ST_W-1:0]      f_tgt;
  logic [TRIG_W-1:0]    f_trig;
  logic [PROB_BITS-1:0] f_prob;
  logic [TRIG_W-1:0]    f_ev;
  logic [ST_W-1:0]      f_qidx;

  assign f_slot  = in_tdata[5:0];
  assign f_valid = in_tdata[6];
  assign f_src   = in_tdata[10:7];
  assign f_tgt   = in_tdata[14:11];
  assign f_trig  = in_tdata[22:15];
  assign f_prob  = in_tdata[38:23];
  assign f_ev    = in_tdata[46:39];
  assign f_qidx  = in_tdata[50:47];

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (state_count_r == '0) begin
      n_used = CNT_W'(1);
    end else if (state_count_r > CNT_W'(NUM_STATES)) begin
      n_used = CNT_W'(NUM_STATES);
    end else begin
      n_used = state_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_count_r   <= CNT_W'(NUM_STATES);
      initial_state_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_STATE_COUNT) begin
        state_count_r <= cfg_wdata;
      end else begin
        initial_state_r <= cfg_wdata[ST_W-1:0];
      end
    end
  end

  // Transition table
  logic         tbl_we;
  trans_entry_t tbl_wentry;
  logic         tbl_re;
  logic [IDX_W-1:0] tbl_raddr;
  trans_entry_t tbl_rentry;
  logic [TCNT_W-1:0] tidx_inc;

  assign tbl_we = in_acc && (in_tuser == OP_WRITE) && (32'(f_slot) < MAX_TRANSITIONS);
  assign tbl_wentry.valid  = f_valid;
  assign tbl_wentry.source = f_src;
  assign tbl_wentry.target = f_tgt;
  assign tbl_wentry.trig   = f_trig;
  assign tbl_wentry.prob   = (f_prob > PROB_ONE) ? PROB_ONE : f_prob;

  assign tidx_inc  = tidx_r + TCNT_W'(1);
  assign tbl_re    = (state_r == S_PRIME) || (state_r == S_MUL);
  assign tbl_raddr = (state_r == S_MUL) ? tidx_inc[IDX_W-1:0] : tidx_r[IDX_W-1:0];

  pst_table #(
    .DEPTH (MAX_TRANSITIONS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (tbl_we),
    .wr_addr  (IDX_W'(f_slot)),
    .wr_entry (tbl_wentry),
    .rd_en    (tbl_re),
    .rd_addr  (tbl_raddr),
    .rd_entry (tbl_rentry)
  );

  // Entry match and flow
  logic                 e_ok;
  logic [PROB_BITS-1:0] flow;
  logic [PROB_BITS-1:0] src_rest;

  assign e_ok = tbl_rentry.valid && (tbl_rentry.trig == ev_r) &&
                ({1'b0, tbl_rentry.source} < n_used) &&
                ({1'b0, tbl_rentry.target} < n_used) &&
                (tbl_rentry.target != tbl_rentry.source);
  assign flow     = prod_r[FRAC_BITS +: PROB_BITS];
  assign src_rest = rest_r[src_r];

  // Scan value for the current state
  logic                 s_used;
  logic [INFLOW_W-1:0]  merged;
  logic [PROB_BITS-1:0] s_val;

  assign s_used = ({1'b0, sidx_r} < n_used);
  assign merged = INFLOW_W'(rest_r[sidx_r]) + inflow_r[sidx_r];

  always_comb begin
    case (op_r)
      OP_TRIGGER: begin
        if (!s_used) begin
          s_val = prob_r[sidx_r];
        end else if (merged > INFLOW_W'(PROB_ONE)) begin
          s_val = PROB_ONE;
        end else begin
          s_val = merged[PROB_BITS-1:0];
        end
      end
      OP_RESET: begin
        s_val = ((sidx_r == qidx_r) && s_used) ? PROB_ONE : '0;
      end
      default: begin
        s_val = prob_r[sidx_r];
      end
    endcase
  end

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tidx_r      <= '0;
      sidx_r      <= '0;
      for (int i = 0; i < NUM_STATES; i++) begin
        prob_r[i] <= (i == 0) ? PROB_ONE : '0;
      end
    end else begin
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            tidx_r <= '0;
            sidx_r <= '0;
            if (in_tuser == OP_TRIGGER) begin
              state_r <= S_PRIME;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_PRIME: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          tidx_r  <= tidx_inc;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (tidx_r == T_LAST) begin
            state_r <= S_SCAN;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_SCAN: begin
          prob_r[sidx_r] <= s_val;
          sidx_r         <= sidx_r + ST_W'(1);
          if (sidx_r == ST_W'(NUM_STATES - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_tuser;
      ev_r    <= f_ev;
      qidx_r  <= f_qidx;
      best_r  <= initial_state_r;
      bestp_r <= '0;
      qprob_r <= '0;
      for (int i = 0; i < NUM_STATES; i++) begin
        rest_r[i]   <= prob_r[i];
        inflow_r[i] <= '0;
      end
    end
    if (state_r == S_MUL) begin
      prod_r <= (2*PROB_BITS)'(prob_r[tbl_rentry.source]) * (2*PROB_BITS)'(tbl_rentry.prob);
      src_r  <= tbl_rentry.source;
      tgt_r  <= tbl_rentry.target;
      ok_r   <= e_ok;
    end
    if ((state_r == S_ACC) && ok_r) begin
      rest_r[src_r]   <= (src_rest > flow) ? (src_rest - flow) : '0;
      inflow_r[tgt_r] <= inflow_r[tgt_r] + INFLOW_W'(flow);
    end
    if (state_r == S_SCAN) begin
      if (s_used && (s_val > bestp_r)) begin
        bestp_r <= s_val;
        best_r  <= sidx_r;
      end
      if (s_used && (sidx_r == qidx_r)) begin
        qprob_r <= s_val;
      end
    end
    if ((state_r == S_DONE) && out_free) begin
      o_likely_r <= best_r;
      o_lprob_r  <= bestp_r;
      o_qprob_r  <= qprob_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, o_qprob_r, o_lprob_r, o_likely_r};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input ready right after an accepted item");

  a_lprob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_lprob_r <= PROB_ONE))
    else $error("likely probability above one");

  a_qprob_le_best: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_qprob_r <= o_lprob_r))
    else $error("queried probability above the maximum");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (tidx_r < T_LAST))
    else $error("table walk past the last slot");

endmodule

// ===== rtl/pst_table.sv =====
// Transition table: entry memory with per-slot valid bits and a registered read port.
module pst_table #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  pst_pkg::trans_entry_t wr_entry,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output pst_pkg::trans_entry_t rd_entry
);
  import pst_pkg::*;

  trans_entry_t     mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  trans_entry_t     rd_entry_r;
  trans_entry_t     rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= wr_entry.valid;
    end
  end

  always_comb begin
    rd_word       = mem[rd_addr];
    rd_word.valid = vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= rd_word;
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

// ===== tb/probabilistic_state_tracker_top_test.sv =====
// Self-checking testbench for the probabilistic state tracker top level.
module probabilistic_state_tracker_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pst_pkg::*;

  localparam int NSLOT = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = OP_QUERY;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_STATE_COUNT;
  logic [CNT_W-1:0] cfg_wdata = '0;

  probabilistic_state_tracker_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [15:0] queried_prob;
    logic [15:0] likely_prob;
    logic [3:0]  likely_state;
  } track_result_t;

  typedef struct {
    logic [1:0] op;
    logic [5:0] slot;
    logic       valid;
    logic [3:0] source;
    logic [3:0] target;
    logic [7:0] trig;
    logic [15:0] prob;
    logic [7:0] ev;
    logic [3:0] idx;
  } track_cmd_t;

  // Shadow of the tracker state
  logic [15:0] mass_q[16];
  trans_entry_t table_q[NSLOT];
  logic [4:0] count_q;
  logic [3:0] init_q;

  track_result_t expected_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  bit out_stall_en = 1;
  bit in_stall_en = 1;
  int hold_off = 0;

  function automatic int in_use();
    if (count_q == 0) return 1;
    if (count_q > 16) return 16;
    return count_q;
  endfunction

  function automatic void shadow_reset();
    foreach (mass_q[i]) mass_q[i] = '0;
    mass_q[0] = PROB_ONE;
    foreach (table_q[i]) table_q[i] = '0;
    count_q = 5'd16;
    init_q = 4'd0;
  endfunction

  function automatic void shadow_trigger(logic [7:0] ev, int n);
    logic [22:0] inflow[16];
    logic [15:0] rest[16];
    logic [31:0] flow;
    logic [22:0] v;
    foreach (inflow[i]) inflow[i] = '0;
    for (int s = 0; s < n; s++) begin
      rest[s] = mass_q[s];
      if (mass_q[s] == 0) continue;
      for (int t = 0; t < NSLOT; t++) begin
        if (!table_q[t].valid || table_q[t].source != s || table_q[t].trig != ev) continue;
        if (table_q[t].target == s || table_q[t].target >= n) continue;
        flow = (32'(mass_q[s]) * 32'(table_q[t].prob)) >> FRAC_BITS;
        inflow[table_q[t].target] += 23'(flow);
        rest[s] = (32'(rest[s]) > flow) ? rest[s] - 16'(flow) : 16'd0;
      end
    end
    for (int s = 0; s < n; s++) begin
      v = 23'(rest[s]) + inflow[s];
      mass_q[s] = (v > 23'(PROB_ONE)) ? PROB_ONE : v[15:0];
    end
  endfunction

  function automatic track_result_t predict_track(track_cmd_t c);
    track_result_t r;
    int n;
    n = in_use();
    case (c.op)
      OP_WRITE: begin
        table_q[c.slot].valid = c.valid;
        table_q[c.slot].source = c.source;
        table_q[c.slot].target = c.target;
        table_q[c.slot].trig = c.trig;
        table_q[c.slot].prob = (c.prob > PROB_ONE) ? PROB_ONE : c.prob;
      end
      OP_TRIGGER: shadow_trigger(c.ev, n);
      OP_RESET: begin
        foreach (mass_q[i]) mass_q[i] = '0;
        if (c.idx < n) mass_q[c.idx] = PROB_ONE;
      end
      default: ;
    endcase
    r.likely_state = init_q;
    r.likely_prob = '0;
    for (int s = 0; s < n; s++)
      if (mass_q[s] > r.likely_prob) begin
        r.likely_prob = mass_q[s];
        r.likely_state = 4'(s);
      end
    r.queried_prob = (c.idx < n) ? mass_q[c.idx] : 16'd0;
    return r;
  endfunction

  task automatic send_item(track_cmd_t c);
    int gap;
    if (in_stall_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c.op;
    in_tdata <= {c.idx, c.ev, c.prob, c.trig, c.target, c.source, c.valid, c.slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(predict_track(c));
  endtask

  always @(posedge clk) begin
    track_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[35:0];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want || out_tdata[39:36] !== 4'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: state exp %0d got %0d, likely exp %0d got %0d, %s %0d got %0d",
                     want.likely_state, got.likely_state, want.likely_prob, got.likely_prob,
                     "query exp", want.queried_prob, got.queried_prob);
        end
      end
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (out_stall_en && $urandom_range(0, 7) == 0) begin
      hold_off <= $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("[probabilistic_state_tracker_top] ERROR");
      $finish;
    end
  end

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_STATE_COUNT) count_q = val;
    else init_q = val[3:0];
    @(posedge clk);
  endtask

  function automatic track_cmd_t rand_cmd();
    track_cmd_t c;
    c.op = 2'($urandom_range(0, 3));
    c.slot = 6'($urandom);
    c.valid = 1'($urandom);
    c.source = 4'($urandom);
    c.target = 4'($urandom);
    c.trig = 8'($urandom);
    c.prob = 16'($urandom);
    c.ev = 8'($urandom);
    c.idx = 4'($urandom);
    return c;
  endfunction

  function automatic track_cmd_t entry_cmd(int slot, int src, int dst, int tr, int p);
    track_cmd_t c;
    c = rand_cmd();
    c.op = OP_WRITE; c.slot = 6'(slot); c.valid = 1'b1;
    c.source = 4'(src); c.target = 4'(dst); c.trig = 8'(tr); c.prob = 16'(p);
    return c;
  endfunction

  function automatic track_cmd_t op_cmd(logic [1:0] op, int ev, int idx);
    track_cmd_t c;
    c = rand_cmd();
    c.op = op; c.ev = 8'(ev); c.idx = 4'(idx);
    return c;
  endfunction

  task automatic test_directed();
    send_item(op_cmd(OP_QUERY, 0, 0));
    send_item(entry_cmd(0, 0, 1, 8'hFF, 16'hFFFF));
    send_item(entry_cmd(1, 0, 0, 8'hFF, 16384));
    send_item(entry_cmd(63, 1, 2, 8'h00, 16384));
    send_item(entry_cmd(2, 2, 15, 8'h00, 12345));
    send_item(entry_cmd(3, 2, 3, 8'h00, 30000));
    send_item(entry_cmd(4, 3, 3, 8'h41, 0));
    send_item(op_cmd(OP_TRIGGER, 8'hFF, 1));
    send_item(op_cmd(OP_TRIGGER, 8'h00, 2));
    send_item(op_cmd(OP_TRIGGER, 8'h00, 15));
    send_item(op_cmd(OP_TRIGGER, 8'h41, 3));
    send_item(op_cmd(OP_RESET, 0, 15));
    send_item(op_cmd(OP_QUERY, 0, 15));
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_STATE_COUNT, 5'd0);
    write_reg(REG_INITIAL_STATE, 4'd9);
    send_item(op_cmd(OP_RESET, 0, 5));
    send_item(op_cmd(OP_QUERY, 0, 0));
    send_item(op_cmd(OP_RESET, 0, 0));
    send_item(op_cmd(OP_TRIGGER, 8'hFF, 0));
    drain();
    write_reg(REG_STATE_COUNT, 5'd31);
    write_reg(REG_INITIAL_STATE, 4'd15);
    send_item(op_cmd(OP_RESET, 0, 15));
    send_item(op_cmd(OP_QUERY, 0, 3));
    drain();
    write_reg(REG_STATE_COUNT, 5'd3);
    send_item(op_cmd(OP_TRIGGER, 8'h00, 14));
    send_item(op_cmd(OP_QUERY, 0, 15));
    drain();
  endtask

  task automatic random_phase(int items, int nstates, int ntrig);
    track_cmd_t c;
    for (int i = 0; i < items; i++) begin
      c = rand_cmd();
      c.ev = 8'($urandom_range(0, ntrig));
      if ($urandom_range(0, 9) != 0) begin
        c.trig = 8'($urandom_range(0, ntrig));
        c.source = 4'($urandom_range(0, nstates));
        c.target = 4'($urandom_range(0, nstates));
        if ($urandom_range(0, 9) != 0) c.prob = 16'($urandom_range(0, 32768));
        if (c.op == OP_RESET && $urandom_range(0, 3) != 0) c.idx = 4'($urandom_range(0, nstates));
      end
      send_item(c);
    end
  endtask

  task automatic test_random();
    int cnt;
    for (int ph = 0; ph < 5; ph++) begin
      cnt = $urandom_range(2, 16);
      write_reg(REG_STATE_COUNT, 5'(cnt));
      write_reg(REG_INITIAL_STATE, 4'($urandom));
      random_phase(300, cnt, 3);
      drain();
    end
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_off = 400;
    @(posedge clk);
    for (int i = 0; i < 6; i++) send_item(op_cmd(OP_QUERY, 0, i));
    drain();
    random_phase(50, 8, 2);
    drain();
  endtask

  task automatic test_no_idle();
    out_stall_en = 0;
    in_stall_en = 0;
    write_reg(REG_STATE_COUNT, 5'd16);
    random_phase(250, 15, 2);
  endtask

  initial begin
    shadow_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random();
    test_backpressure();
    test_no_idle();
    drain();
    if (mismatches == 0) $display("[probabilistic_state_tracker_top] OK");
    else $display("[probabilistic_state_tracker_top] ERROR");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/pst_pkg.sv
rtl/pst_table.sv
rtl/probabilistic_state_tracker_top.sv
tb/probabilistic_state_tracker_top_test.sv
